/* hw/rtl/iis_pkg.sv */
// shared types and constants of the integer image scaler
package iis_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_FACTOR_DEF = 8;
	localparam int MAX_HEIGHT     = 4096;
	localparam int HEIGHT_W       = 13;
	localparam int ROW_W          = 12;
	localparam int RGB_W          = 24;
	localparam int FACTOR_REG_W   = 4;
	localparam int WIDTH_REG_W    = 11;
	localparam int CFG_W          = 13;
	localparam int CFG_IDX_W      = 2;

	localparam logic OP_PIXEL      = 1'b0;
	localparam logic OP_TICK       = 1'b1;
	localparam logic MODE_ENLARGE  = 1'b0;
	localparam logic MODE_SHRINK   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_FACTOR = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_PAD    = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	// what one accepted word turns into, apart from the pixel copy count
	typedef struct packed {
		logic             reject;
		logic             use_mem;
		logic [1:0]       n_pad;
		logic [RGB_W-1:0] rgb;
	} desc_t;

endpackage

/* hw/rtl/integer_image_scaler_top.sv */
// nearest-neighbour integer image scaler, top level
//
// pixels arrive on the s_ stream in row order: tuser 0 carries a pixel, tuser 1 is a
// tick that plays back one column of a pending row replay. results leave on the m_
// stream: tuser gives the kind (pixel, pad byte, rejected pixel), tlast marks the
// final word caused by one input word. configuration goes in through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// as the block itself does not enforce this. an accepted word is registered in
// stage one and then loaded into the result sequencer. one output word leaves per
// cycle while m_tready is high; an input word yields 1 to 10 results (eight
// copies come with no pad, seven copies with up to three pad bytes) or none.
// the rate is set by the result sequencer; the line store is a single ram, written
// by enlarge-mode pixels and read by replay ticks, at most one per accepted word.
// after every configuration write the shared divider recomputes the kept row and
// column limits, holding s_tready low while the write is pending and while it runs.
// reset clears all counters and loads mode 0, factor 1, width 1, height 1; the line
// store keeps whatever it held. when the receiver stalls the sequencer holds its
// word and one more descriptor waits in stage one before s_tready drops.
module integer_image_scaler_top
	import iis_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [RGB_W-1:0]     s_tdata,  // red [7:0], green [15:8], blue [23:16]
	input  logic                 s_tuser,  // op
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [RGB_W-1:0]     m_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
	output logic [1:0]           m_tuser,  // kind
	output logic                 m_tlast
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = ($clog2(MAX_WIDTH + 1) > 2) ? $clog2(MAX_WIDTH + 1) : 2;
	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int DW = (WW > HEIGHT_W) ? WW : HEIGHT_W;

	logic                    mode_q;
	logic [FACTOR_REG_W-1:0] factor_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_W-1:0]     height_q;
	logic                    cfg_pend_q;

	logic [FW-1:0]       f_eff;
	logic [WW-1:0]       w_eff, lim_w;
	logic [HEIGHT_W-1:0] h_eff, lim_h;
	logic                div_busy;
	logic [FW-1:0]       rem_w, rem_h;
	logic [DW-1:0]       quo_w;

	logic                accept, adv, take, valid_s1;
	desc_t               desc_s1;
	logic [FW-1:0]       n_pix_s1;
	logic                ram_we, ram_re;
	logic [CW-1:0]       ram_waddr, ram_raddr;
	logic [RGB_W-1:0]    ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_ENLARGE;
			factor_q   <= FACTOR_REG_W'(1);
			width_q    <= WIDTH_REG_W'(1);
			height_q   <= HEIGHT_W'(1);
			cfg_pend_q <= 1'b0;
		end else begin
			cfg_pend_q <= cfg_we;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_MODE:   mode_q   <= cfg_data[0];
					REG_FACTOR: factor_q <= cfg_data[FACTOR_REG_W-1:0];
					REG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				endcase
			end
		end
	end

	// registers saturate to their legal ranges
	always_comb begin
		if (factor_q == '0) begin
			f_eff = FW'(1);
		end else if (32'(factor_q) > MAX_FACTOR) begin
			f_eff = FW'(MAX_FACTOR);
		end else begin
			f_eff = FW'(factor_q);
		end
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HEIGHT_W'(1);
		end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		// first column and row past the last whole block of factor size
		lim_w = w_eff - WW'(rem_w);
		lim_h = h_eff - HEIGHT_W'(rem_h);
	end

	iis_div #(
		.DW (DW),
		.FW (FW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_pend_q),
		.divisor (f_eff),
		.a       (DW'(w_eff)),
		.b       (DW'(h_eff)),
		.busy    (div_busy),
		.rem_a   (rem_w),
		.rem_b   (rem_h),
		.quo_a   (quo_w)
	);

	assign s_tready = !cfg_we && !cfg_pend_q && !div_busy && (!valid_s1 || take);
	assign accept   = s_tvalid && s_tready;
	assign adv      = valid_s1 && take;

	iis_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (s_tuser),
		.rgb       (s_tdata),
		.mode      (mode_q),
		.f_eff     (f_eff),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.lim_w     (lim_w),
		.lim_h     (lim_h),
		.kept_lo   (quo_w[1:0]),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.desc_s1   (desc_s1),
		.n_pix_s1  (n_pix_s1),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	iis_ram #(
		.WIDTH (RGB_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iis_gen #(
		.FW (FW)
	) u_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.desc     (desc_s1),
		.n_pix    (n_pix_s1),
		.mem_rgb  (ram_rdata),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* hw/rtl/iis_ram.sv */
// generic simple dual-port ram with registered read
module iis_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/iis_div.sv */
// restoring divider that splits two dividends by the scale factor, one bit a cycle
module iis_div #(
	parameter int DW = 13,
	parameter int FW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [FW-1:0] divisor,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic          busy,
	output logic [FW-1:0] rem_a,
	output logic [FW-1:0] rem_b,
	output logic [DW-1:0] quo_a
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [FW-1:0]    d_q;
	logic [FW-1:0]    ra_q, rb_q;
	logic [DW-1:0]    qa_q, qb_q;
	logic [FW:0]      ta, tb;
	logic             ge_a, ge_b;
	logic [FW-1:0]    ra_n, rb_n;

	always_comb begin
		ta   = {ra_q, qa_q[DW-1]};
		tb   = {rb_q, qb_q[DW-1]};
		ge_a = ta >= {1'b0, d_q};
		ge_b = tb >= {1'b0, d_q};
		ra_n = ge_a ? FW'(ta - {1'b0, d_q}) : FW'(ta);
		rb_n = ge_b ? FW'(tb - {1'b0, d_q}) : FW'(tb);
	end

	// reset values match the reset geometry: one by one by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			d_q    <= FW'(1);
			ra_q   <= '0;
			rb_q   <= '0;
			qa_q   <= DW'(1);
			qb_q   <= DW'(1);
		end else if (start) begin
			cnt_q  <= CNT_W'(DW);
			busy_q <= 1'b1;
			d_q    <= divisor;
			ra_q   <= '0;
			rb_q   <= '0;
			qa_q   <= a;
			qb_q   <= b;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
			ra_q <= ra_n;
			rb_q <= rb_n;
			qa_q <= {qa_q[DW-2:0], ge_a};
			qb_q <= {qb_q[DW-2:0], ge_b};
		end
	end

	assign busy  = busy_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;
	assign quo_a = qa_q;

endmodule

/* hw/rtl/iis_ctrl.sv */
// row and column bookkeeping, line store access and the per-word result descriptor
module iis_ctrl
	import iis_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF,
	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int WW  = ($clog2(MAX_WIDTH + 1) > 2) ? $clog2(MAX_WIDTH + 1) : 2,
	localparam int FW  = $clog2(MAX_FACTOR + 1),
	localparam int PW  = $clog2(MAX_FACTOR)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                op,
	input  logic [RGB_W-1:0]    rgb,
	input  logic                mode,
	input  logic [FW-1:0]       f_eff,
	input  logic [WW-1:0]       w_eff,
	input  logic [HEIGHT_W-1:0] h_eff,
	input  logic [WW-1:0]       lim_w,
	input  logic [HEIGHT_W-1:0] lim_h,
	input  logic [1:0]          kept_lo,
	input  logic                adv,
	output logic                valid_s1,
	output desc_t               desc_s1,
	output logic [FW-1:0]       n_pix_s1,
	output logic                ram_we,
	output logic [CW-1:0]       ram_waddr,
	output logic [RGB_W-1:0]    ram_wdata,
	output logic                ram_re,
	output logic [CW-1:0]       ram_raddr
);

	logic [CW-1:0]    col_q, rcol_q;
	logic [ROW_W-1:0] row_q;
	logic [PW-1:0]    rleft_q, cph_q, rph_q;

	logic [CW-1:0]    col_n, rcol_n;
	logic [ROW_W-1:0] row_n;
	logic [PW-1:0]    rleft_n, cph_n, rph_n;

	logic             col_end, rep_end, row_wrap, rph_wrap, cph_wrap;
	logic             row_kept, col_kept, pending, has_res;
	logic [1:0]       pad_w;
	desc_t            desc;
	logic [FW-1:0]    n_pix;

	always_comb begin
		// pad bytes of an enlarged row equal its pixel count modulo four
		pad_w    = 2'(w_eff[1:0] * f_eff[1:0]);
		col_end  = (WW'(col_q) + WW'(1)) >= w_eff;
		rep_end  = (WW'(rcol_q) + WW'(1)) >= w_eff;
		row_wrap = (HEIGHT_W'(row_q) + HEIGHT_W'(1)) >= h_eff;
		rph_wrap = (FW'(rph_q) + FW'(1)) >= f_eff;
		cph_wrap = (FW'(cph_q) + FW'(1)) >= f_eff;
		row_kept = (rph_q == '0) && (HEIGHT_W'(row_q) < lim_h);
		col_kept = (cph_q == '0) && (WW'(col_q) < lim_w);
		pending  = rleft_q != '0;
	end

	always_comb begin
		col_n        = col_q;
		rcol_n       = rcol_q;
		row_n        = row_q;
		rleft_n      = rleft_q;
		cph_n        = cph_q;
		rph_n        = rph_q;
		has_res      = 1'b0;
		desc.reject  = 1'b0;
		desc.use_mem = 1'b0;
		desc.n_pad   = 2'd0;
		desc.rgb     = rgb;
		n_pix        = '0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		if (accept) begin
			if (op == OP_TICK) begin
				if (pending) begin
					has_res      = 1'b1;
					desc.use_mem = 1'b1;
					n_pix        = f_eff;
					ram_re       = 1'b1;
					if (rep_end) begin
						desc.n_pad = pad_w;
						rcol_n     = '0;
						rleft_n    = rleft_q - PW'(1);
					end else begin
						rcol_n = CW'(rcol_q + 1'b1);
					end
				end
			end else if (pending) begin
				has_res     = 1'b1;
				desc.reject = 1'b1;
			end else if (mode == MODE_ENLARGE) begin
				has_res = 1'b1;
				ram_we  = 1'b1;
				n_pix   = f_eff;
				if (col_end) begin
					desc.n_pad = pad_w;
					col_n      = '0;
					cph_n      = '0;
					rleft_n    = PW'(f_eff - FW'(1));
					rcol_n     = '0;
					row_n      = row_wrap ? '0 : ROW_W'(row_q + 1'b1);
					rph_n      = rph_wrap ? '0 : PW'(rph_q + 1'b1);
				end else begin
					col_n = CW'(col_q + 1'b1);
				end
			end else begin
				n_pix = (row_kept && col_kept) ? FW'(1) : '0;
				if (col_end) begin
					// pad of a kept row rides on its last source pixel
					desc.n_pad = row_kept ? kept_lo : 2'd0;
					col_n      = '0;
					cph_n      = '0;
					row_n      = row_wrap ? '0 : ROW_W'(row_q + 1'b1);
					rph_n      = rph_wrap ? '0 : PW'(rph_q + 1'b1);
				end else begin
					col_n = CW'(col_q + 1'b1);
					cph_n = cph_wrap ? '0 : PW'(cph_q + 1'b1);
				end
				has_res = (n_pix != '0) || (desc.n_pad != 2'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			rcol_q   <= '0;
			row_q    <= '0;
			rleft_q  <= '0;
			cph_q    <= '0;
			rph_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			col_q   <= col_n;
			rcol_q  <= rcol_n;
			row_q   <= row_n;
			rleft_q <= rleft_n;
			cph_q   <= cph_n;
			rph_q   <= rph_n;
			if (accept) begin
				valid_s1 <= has_res;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1  <= desc;
			n_pix_s1 <= n_pix;
		end
	end

	assign ram_waddr = col_q;
	assign ram_wdata = rgb;
	assign ram_raddr = rcol_q;

endmodule

/* hw/rtl/iis_gen.sv */
// result sequencer: pixel copies, pads or a reject, one word a cycle unless stalled
module iis_gen
	import iis_pkg::*;
#(
	parameter int FW = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  desc_t            desc,
	input  logic [FW-1:0]    n_pix,
	input  logic [RGB_W-1:0] mem_rgb,
	output logic             take,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [RGB_W-1:0] m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	logic             valid_q;
	logic             reject_q;
	logic [RGB_W-1:0] rgb_q;
	logic [FW-1:0]    pix_q;
	logic [1:0]       pad_q;
	logic             last;
	kind_t            kind;

	always_comb begin
		last = reject_q || ((pix_q == FW'(1)) && (pad_q == 2'd0))
			|| ((pix_q == '0) && (pad_q == 2'd1));
		if (reject_q) begin
			kind = KIND_REJECT;
		end else if (pix_q != '0) begin
			kind = KIND_PIXEL;
		end else begin
			kind = KIND_PAD;
		end
	end

	assign take     = !valid_q || (last && m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = (kind == KIND_PIXEL) ? rgb_q : '0;
	assign m_tuser  = kind;
	assign m_tlast  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (valid_q && m_tready && last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			reject_q <= desc.reject;
			rgb_q    <= desc.use_mem ? mem_rgb : desc.rgb;
			pix_q    <= n_pix;
			pad_q    <= desc.n_pad;
		end else if (valid_q && m_tready) begin
			if (pix_q != '0) begin
				pix_q <= pix_q - FW'(1);
			end else if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end
		end
	end

endmodule

/* sim/integer_image_scaler_top_test.sv */
// self-checking testbench for the integer image scaler top level
module integer_image_scaler_top_test
	import iis_pkg::*;
();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		kind_t            kind;
		logic [RGB_W-1:0] data;
		logic             last;
	} scaled_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [RGB_W-1:0]     s_tdata = '0;  // red [7:0], green [15:8], blue [23:16]
	logic                 s_tuser = OP_PIXEL;  // op
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [RGB_W-1:0]     m_tdata;  // out_red [7:0], out_green [15:8], out_blue [23:16]
	logic [1:0]           m_tuser;  // kind
	logic                 m_tlast;

	// scaler state as the testbench sees it
	logic                    mode_reg = MODE_ENLARGE;
	logic [FACTOR_REG_W-1:0] factor_reg = FACTOR_REG_W'(1);
	logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_REG_W'(1);
	logic [HEIGHT_W-1:0]     height_reg = HEIGHT_W'(1);
	logic [RGB_W-1:0]        line_store [MAX_WIDTH_DEF];
	int col_count = 0, row_count = 0, replays_left = 0, replay_col = 0;
	int col_phase = 0, row_phase = 0;

	scaled_word_t scaled_words_due[$];
	scaled_word_t step_words[$];
	scaled_word_t due_word;

	int idle_pct = 0, stall_pct = 0;
	int hold_requests = 0, holds_served = 0, hold_left = 0;
	int words_sent = 0, words_checked = 0, mismatches = 0;
	int cycle_count = 0;

	integer_image_scaler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d words outstanding", $time,
				scaled_words_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off whenever one is requested
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else
			m_tready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (scaled_words_due.size() == 0) begin
				$display("%0t: unexpected word kind %0d data %h last %b", $time,
					m_tuser, m_tdata, m_tlast);
				mismatches++;
			end else begin
				due_word = scaled_words_due.pop_front();
				words_checked++;
				if (m_tuser !== due_word.kind || m_tdata !== due_word.data ||
						m_tlast !== due_word.last) begin
					$display("%0t: expected kind %0d data %h last %b, got kind %0d data %h last %b",
						$time, due_word.kind, due_word.data, due_word.last,
						m_tuser, m_tdata, m_tlast);
					mismatches++;
				end
			end
		end
	end

	function automatic int eff_factor();
		if (factor_reg == 0) return 1;
		if (factor_reg > MAX_FACTOR_DEF) return MAX_FACTOR_DEF;
		return int'(factor_reg);
	endfunction

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic logic [RGB_W-1:0] pick_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return RGB_W'($urandom);
		endcase
	endfunction

	task automatic add_word(input kind_t kind, input logic [RGB_W-1:0] data);
		scaled_word_t w;
		w.kind = kind;
		w.data = data;
		w.last = 1'b0;
		step_words.push_back(w);
	endtask

	// zero bytes that bring a row of 3-byte pixels to a 4-byte boundary
	task automatic add_pad(input int pixels);
		int pad, k;
		pad = (4 - (pixels * 3) % 4) % 4;
		for (k = 0; k < pad; k++)
			add_word(KIND_PAD, '0);
	endtask

	task automatic advance_row(input int f, input int h);
		row_count++;
		if (row_count >= h) row_count = 0;
		row_phase++;
		if (row_phase >= f) row_phase = 0;
	endtask

	// works out the words one accepted input word yields and queues them
	task automatic scale_word(input logic op, input logic [RGB_W-1:0] pix);
		int f, w, h, kept_cols, k;
		bit row_kept;
		scaled_word_t sw;
		f = eff_factor();
		w = eff_width();
		h = eff_height();
		step_words.delete();
		if (op == OP_TICK) begin
			if (replays_left != 0) begin
				for (k = 0; k < f; k++)
					add_word(KIND_PIXEL, line_store[replay_col]);
				if (replay_col + 1 >= w) begin
					add_pad(w * f);
					replay_col = 0;
					replays_left--;
				end else
					replay_col++;
			end
		end else if (replays_left != 0) begin
			add_word(KIND_REJECT, '0);
		end else if (mode_reg == MODE_ENLARGE) begin
			line_store[col_count] = pix;
			for (k = 0; k < f; k++)
				add_word(KIND_PIXEL, pix);
			if (col_count + 1 >= w) begin
				add_pad(w * f);
				col_count = 0;
				col_phase = 0;
				replays_left = f - 1;
				replay_col = 0;
				advance_row(f, h);
			end else
				col_count++;
		end else begin
			kept_cols = w / f;
			row_kept = (row_phase == 0) && (row_count / f < h / f);
			if (row_kept && col_phase == 0 && col_count / f < kept_cols)
				add_word(KIND_PIXEL, pix);
			if (col_count + 1 >= w) begin
				// a kept row pads even when it kept no pixel
				if (row_kept) add_pad(kept_cols);
				col_count = 0;
				col_phase = 0;
				advance_row(f, h);
			end else begin
				col_count++;
				col_phase++;
				if (col_phase >= f) col_phase = 0;
			end
		end
		for (k = 0; k < step_words.size(); k++) begin
			sw = step_words[k];
			sw.last = (k == step_words.size() - 1);
			scaled_words_due.push_back(sw);
		end
	endtask

	task automatic send_word(input logic op, input logic [RGB_W-1:0] pix);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		scale_word(op, pix);
		words_sent++;
	endtask

	// sender stops until every due word is back and the pipeline has emptied
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (scaled_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			REG_MODE:   mode_reg = data[0];
			REG_FACTOR: factor_reg = data[FACTOR_REG_W-1:0];
			REG_WIDTH:  width_reg = data[WIDTH_REG_W-1:0];
			REG_HEIGHT: height_reg = data[HEIGHT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// finish the current row and play out any pending replay
	task automatic settle_row();
		while (col_count != 0 || replays_left != 0)
			send_word(replays_left != 0 ? OP_TICK : OP_PIXEL, pick_pixel());
	endtask

	task automatic set_config(input logic [CFG_W-1:0] m, f, w, h);
		// a new width or a return to enlarge must start on a clean row, otherwise a
		// replay could read store entries never written
		if (w[WIDTH_REG_W-1:0] != width_reg || (m[0] == MODE_ENLARGE && mode_reg == MODE_SHRINK))
			settle_row();
		wait_idle();
		write_reg(REG_MODE, m);
		write_reg(REG_FACTOR, f);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic send_random_items(input int count);
		int i;
		logic op;
		for (i = 0; i < count; i++) begin
			if (replays_left != 0)
				op = ($urandom_range(99) < 85) ? OP_TICK : OP_PIXEL;
			else
				op = ($urandom_range(99) < 8) ? OP_TICK : OP_PIXEL;
			send_word(op, pick_pixel());
		end
	endtask

	task automatic random_config();
		logic [CFG_W-1:0] junk, m, f, w, h;
		logic [FACTOR_REG_W-1:0] fac;
		logic [WIDTH_REG_W-1:0] wid;
		logic md;
		md = ($urandom_range(1) == 1) ? MODE_SHRINK : MODE_ENLARGE;
		fac = ($urandom_range(9) == 0) ? FACTOR_REG_W'($urandom_range(15))
			: FACTOR_REG_W'($urandom_range(8, 1));
		wid = ($urandom_range(19) == 0) ? '0 : WIDTH_REG_W'($urandom_range(6, 1));
		h = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(8191, 4097))
			: CFG_W'($urandom_range(10));
		// now and then keep mode and width so the write lands mid-row
		if ($urandom_range(2) == 0) begin
			md = mode_reg;
			wid = width_reg;
		end
		// stray bits above each register's width
		junk = ($urandom_range(3) == 0) ? CFG_W'($urandom) : '0;
		m = {junk[CFG_W-1:1], md};
		f = {junk[CFG_W-1:FACTOR_REG_W], fac};
		w = {junk[CFG_W-1:WIDTH_REG_W], wid};
		set_config(m, f, w, h);
	endtask

	task automatic test_reset_defaults();
		send_word(OP_PIXEL, 24'h000000);
		send_word(OP_PIXEL, 24'hFFFFFF);
		send_word(OP_TICK, 24'hFFFFFF);
		wait_idle();
	endtask

	task automatic test_enlarge_replay();
		int k;
		set_config(CFG_W'(MODE_ENLARGE), 13'd3, 13'd2, 13'd2);
		send_word(OP_PIXEL, 24'h123456);
		send_word(OP_PIXEL, 24'hA5C3E7);
		// pixel while the row replay is pending is rejected
		send_word(OP_PIXEL, 24'h5A5A5A);
		for (k = 0; k < 5; k++)
			send_word(OP_TICK, 24'h000000);
		wait_idle();
	endtask

	task automatic test_shrink_decimation();
		int k;
		set_config(CFG_W'(MODE_SHRINK), 13'd2, 13'd3, 13'd4);
		for (k = 0; k < 9; k++)
			send_word(OP_PIXEL, pick_pixel());
		send_word(OP_TICK, 24'hFFFFFF);
		wait_idle();
	endtask

	task automatic test_register_limits();
		int k;
		// factor 15, width 0 and height 0 saturate to 8, 1 and 1
		set_config(CFG_W'(MODE_ENLARGE), 13'h000F, 13'h0000, 13'h0000);
		send_word(OP_PIXEL, 24'hFFFFFF);
		// shrink with the replay still pending; factor 0 reads as 1, height as 4096
		set_config(13'h1FFF, 13'h1FF0, 13'h0000, 13'h1FFF);
		for (k = 0; k < 7; k++)
			send_word(OP_TICK, 24'h000000);
		send_word(OP_PIXEL, 24'h00FF00);
		send_word(OP_PIXEL, 24'hFF00FF);
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_config(CFG_W'(MODE_ENLARGE), 13'd4, 13'd3, 13'd5);
		@(posedge clk);
		hold_requests++;
		send_random_items(24);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int ph, n;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			for (n = 0; n < 2; n++) begin
				random_config();
				send_random_items(10);
			end
		end
	endtask

	// the start of a row at the largest width, reached through saturation
	task automatic test_wide_row();
		int k;
		set_config(CFG_W'(MODE_ENLARGE), 13'd1, 13'h07FF, 13'h1FFF);
		for (k = 0; k < 24; k++)
			send_word(OP_PIXEL, pick_pixel());
		wait_idle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_enlarge_replay();
		test_shrink_decimation();
		test_register_limits();
		test_backpressure();
		test_random_traffic();
		test_wide_row();
		wait_idle();
		$display("Sent %0d words through enlarge, shrink, replay, reject and register saturation",
			words_sent);
		$display("Checked %0d result words under idle, stall and long hold-off phases",
			words_checked);
		if (mismatches == 0 && scaled_words_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/iis_pkg.sv
hw/rtl/iis_ram.sv
hw/rtl/iis_div.sv
hw/rtl/iis_ctrl.sv
hw/rtl/iis_gen.sv
hw/rtl/integer_image_scaler_top.sv
sim/integer_image_scaler_top_test.sv
